/* rtl/core/bes_pkg.sv */
// Shared types, constants and helpers for the binned EWMA surprise detector.
// No dependencies.
`default_nettype none
package bes_pkg;

    localparam int NUM_BINS_DEF       = 24;
    localparam int HISTORY_DEPTH_DEF  = 32;
    localparam int WARMUP_SAMPLES_DEF = 10;

    localparam int DW = 64;   // shared unit datapath width
    localparam int IW = 7;    // iteration count width

    localparam logic [15:0] ALPHA_RST = 16'd3277;
    localparam logic [15:0] THR_RST   = 16'd768;
    localparam logic [5:0]  K_RST     = 6'd3;
    localparam logic [5:0]  M_RST     = 6'd5;

    localparam logic [51:0] EPS_Q24   = 52'd17;
    localparam logic [51:0] VAR_MAX   = {52{1'b1}};

    // Iteration counts of the shared unit
    localparam logic [IW-1:0] IT_WDIV  = 7'd24;
    localparam logic [IW-1:0] IT_VDIV  = 7'd52;
    localparam logic [IW-1:0] IT_SQRT  = 7'd26;
    localparam logic [IW-1:0] IT_SDIV  = 7'd32;
    localparam logic [IW-1:0] IT_A     = 7'd16;
    localparam logic [IW-1:0] IT_A1    = 7'd17;
    localparam logic [IW-1:0] IT_MAG   = 7'd24;
    localparam logic [IW-1:0] IT_CNT   = 7'd4;

    // Register indexes
    localparam logic [1:0] REG_ALPHA = 2'd0;
    localparam logic [1:0] REG_THR   = 2'd1;
    localparam logic [1:0] REG_K     = 2'd2;
    localparam logic [1:0] REG_M     = 2'd3;

    typedef enum logic [1:0] {ALU_MUL, ALU_DIV, ALU_SQRT} alu_op_t;

    typedef enum logic [1:0] {A_IDLE, A_RUN, A_DONE} alu_state_t;

    typedef enum logic [1:0] {H_IDLE, H_MOD, H_CNT, H_DONE} hist_state_t;

    typedef enum logic [4:0] {
        S_IDLE, S_LOAD, S_W_DIV, S_W_MUL, S_W_WB,
        S_V_DIV, S_SQRT, S_S_DIV, S_GATE,
        S_M1, S_M2, S_NM, S_M3, S_M4, S_M5, S_M6, S_M7, S_WB,
        S_HIST, S_DONE
    } seq_state_t;

    typedef struct packed {
        logic          start;
        alu_op_t       op;
        logic [IW-1:0] iters;
    } alu_cmd_t;

    function automatic logic [23:0] absdiff24(input logic [23:0] a, input logic [23:0] b);
        return (a < b) ? (b - a) : (a - b);
    endfunction

    function automatic logic [51:0] sat52(input logic [63:0] v);
        return (v > {12'd0, VAR_MAX}) ? VAR_MAX : v[51:0];
    endfunction

endpackage
`default_nettype wire

/* rtl/core/bes_alu.sv */
// Shared iterative unit: shift-add multiply, restoring divide, integer square root.
// One add/subtract per cycle. Depends on bes_pkg.
`default_nettype none
module bes_alu (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire bes_pkg::alu_cmd_t     cmd,
    input  wire logic [bes_pkg::DW-1:0] opa,
    input  wire logic [bes_pkg::DW-1:0] opb,
    output logic                       done,
    output logic [bes_pkg::DW-1:0]     result
);
    import bes_pkg::*;

    alu_state_t    state_reg, state_next;
    alu_op_t       op_reg;
    logic [IW-1:0] it_reg;
    logic [DW-1:0] acc_reg, aux_reg, sh_reg;

    logic [DW-1:0] x_op, y_op, trial, diff;
    logic [DW:0]   sum;
    logic          sub, ge;

    // shared adder
    always_comb
    begin
        trial = {acc_reg[DW-2:0], sh_reg[DW-1]};
        case (op_reg)
            ALU_MUL:
            begin
                x_op = acc_reg;
                y_op = sh_reg[0] ? aux_reg : '0;
                sub  = 1'b0;
            end
            ALU_DIV:
            begin
                x_op = trial;
                y_op = aux_reg;
                sub  = 1'b1;
            end
            default:
            begin
                x_op = acc_reg;
                y_op = aux_reg | sh_reg;
                sub  = 1'b1;
            end
        endcase
        sum  = {1'b0, x_op} + {1'b0, (sub ? ~y_op : y_op)} + {{DW{1'b0}}, sub};
        diff = sum[DW-1:0];
        ge   = sum[DW];
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            A_IDLE: if (cmd.start) state_next = A_RUN;
            A_RUN:  if (it_reg == IW'(1)) state_next = A_DONE;
            A_DONE: state_next = A_IDLE;
            default: state_next = A_IDLE;
        endcase
    end

    always_comb
    begin
        done = (state_reg == A_DONE);
        case (op_reg)
            ALU_MUL: result = acc_reg;
            ALU_DIV: result = sh_reg;
            default: result = aux_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= A_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == A_IDLE && cmd.start)
        begin
            op_reg <= cmd.op;
            it_reg <= cmd.iters;
            case (cmd.op)
                ALU_MUL:
                begin
                    acc_reg <= '0;
                    aux_reg <= opa;
                    sh_reg  <= opb;
                end
                ALU_DIV:
                begin
                    acc_reg <= '0;
                    aux_reg <= opb;
                    // align dividend so its top used bit enters first
                    sh_reg  <= opa << (IW'(DW) - cmd.iters);
                end
                default:
                begin
                    acc_reg <= opa;
                    aux_reg <= '0;
                    sh_reg  <= {{(DW-1){1'b0}}, 1'b1} << {cmd.iters - IW'(1), 1'b0};
                end
            endcase
        end
        else if (state_reg == A_RUN)
        begin
            it_reg <= it_reg - IW'(1);
            case (op_reg)
                ALU_MUL:
                begin
                    acc_reg <= diff;
                    aux_reg <= aux_reg << 1;
                    sh_reg  <= sh_reg >> 1;
                end
                ALU_DIV:
                begin
                    acc_reg <= ge ? diff : trial;
                    sh_reg  <= {sh_reg[DW-2:0], ge};
                end
                default:
                begin
                    if (ge)
                    begin
                        acc_reg <= diff;
                        aux_reg <= (aux_reg >> 1) | sh_reg;
                    end
                    else
                    begin
                        aux_reg <= aux_reg >> 1;
                    end
                    sh_reg <= sh_reg >> 2;
                end
            endcase
        end
    end

endmodule
`default_nettype wire

/* rtl/core/bes_hist.sv */
// Spike history ring: write the flag, advance the pointer modulo m, count the window.
// Depends on bes_pkg.
`default_nettype none
module bes_hist #(
    parameter int HISTORY_DEPTH = bes_pkg::HISTORY_DEPTH_DEF
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  start,
    input  wire logic                                  spike,
    input  wire logic [$clog2(HISTORY_DEPTH+1)-1:0]    m_eff,
    input  wire logic [5:0]                            k_need,
    output logic                                       done,
    output logic                                       trig
);
    import bes_pkg::*;

    localparam int MW = $clog2(HISTORY_DEPTH + 1);
    localparam int PW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;

    hist_state_t            state_reg, state_next;
    logic [HISTORY_DEPTH-1:0] hist_reg;
    logic [PW-1:0]          ptr_reg;
    logic [MW-1:0]          r_reg, idx_reg, cnt_reg, m_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            H_IDLE: if (start) state_next = H_MOD;
            H_MOD:  if (r_reg < m_reg) state_next = H_CNT;
            H_CNT:  if (idx_reg == m_reg) state_next = H_DONE;
            H_DONE: state_next = H_IDLE;
            default: state_next = H_IDLE;
        endcase
    end

    always_comb
    begin
        done = (state_reg == H_DONE);
        trig = (7'(cnt_reg) >= 7'(k_need));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= H_IDLE;
            hist_reg  <= '0;
            ptr_reg   <= '0;
            r_reg     <= '0;
            idx_reg   <= '0;
            cnt_reg   <= '0;
            m_reg     <= MW'(1);
        end
        else
        begin
            state_reg <= state_next;
            case (state_reg)
                H_IDLE:
                begin
                    if (start)
                    begin
                        hist_reg[ptr_reg] <= spike;
                        r_reg <= MW'(ptr_reg) + MW'(1);
                        m_reg <= m_eff;
                    end
                end
                H_MOD:
                begin
                    // pointer can sit past a lowered window: reduce by repeated subtract
                    if (r_reg >= m_reg)
                        r_reg <= r_reg - m_reg;
                    else
                    begin
                        ptr_reg <= r_reg[PW-1:0];
                        idx_reg <= '0;
                        cnt_reg <= '0;
                    end
                end
                H_CNT:
                begin
                    if (idx_reg != m_reg)
                    begin
                        cnt_reg <= cnt_reg + MW'(hist_reg[idx_reg[PW-1:0]]);
                        idx_reg <= idx_reg + MW'(1);
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

endmodule
`default_nettype wire

/* rtl/core/binned_ewma_surprise_detector_unit.sv */
// Binned EWMA surprise detector, top level: sequencer, bin store, config, output register.
// Depends on bes_pkg, bes_alu, bes_hist.
//
// Usage:
//   Input items arrive on s_tvalid/s_tready/s_tdata (bin index and Q12.12 sample),
//   results leave on m_tvalid/m_tready/m_tdata. One result per item, in order.
//   Registers are written through cfg_we/cfg_index/cfg_data; the user must write them
//   only while the block is idle, as the block does not enforce it. One item is worked
//   at a time; s_tready is high only in the idle state. The multiplies, divides and
//   square root go through one shared iterative unit (one add or subtract per cycle).
//   An invalid bin goes straight to the result. A warm-up sample takes a 24-step divide
//   and a 24-step multiply. After warm-up: a 52-step divide, a 26-step square root, a
//   32-step divide and the history pointer and window count, plus seven multiplies
//   when the EWMA update runs.
//   The result sits in an output register; a new item is accepted while it waits.
//   If the receiver stalls, the finished item waits in the sequencer's last state.
//   Reset restores register defaults and clears all bins (per-bin valid bits) and
//   the spike history at once; no clearing pass is needed.
`default_nettype none
module binned_ewma_surprise_detector_unit #(
    parameter int NUM_BINS       = bes_pkg::NUM_BINS_DEF,
    parameter int HISTORY_DEPTH  = bes_pkg::HISTORY_DEPTH_DEF,
    parameter int WARMUP_SAMPLES = bes_pkg::WARMUP_SAMPLES_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // time_bin[4:0], sample_magnitude[28:5], zero pad
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,   // accepted[0], warming_up[1], surprise_score[17:2],
                                        // triggered[18], zero pad
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);
    import bes_pkg::*;

    localparam int BW = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
    localparam int MW = $clog2(HISTORY_DEPTH + 1);

    seq_state_t state_reg, state_next;
    logic       launched_reg, launched_next;

    logic [15:0] alpha_reg, thr_reg;
    logic [5:0]  k_reg, win_reg;

    logic [23:0] mean_mem [NUM_BINS];
    logic [51:0] var_mem  [NUM_BINS];
    logic [3:0]  cnt_mem  [NUM_BINS];
    logic [NUM_BINS-1:0] vld_reg;

    logic [4:0]  bin_reg;
    logic [23:0] x_reg, mu_reg, nm_reg;
    logic [51:0] vs_reg, v_reg;
    logic [3:0]  cnt_reg;
    logic [25:0] s_reg;
    logic [15:0] sur_reg;
    logic [63:0] p_reg, vn_reg;
    logic [47:0] inst_reg;

    logic        m_tvalid_reg;
    logic        o_acc_reg, o_warm_reg, o_trig_reg;
    logic [15:0] o_sur_reg;
    logic        r_acc_reg, r_warm_reg, r_trig_reg;

    alu_cmd_t    alu_cmd;
    logic [63:0] alu_a, alu_b, alu_res;
    logic        alu_done;

    logic        hist_start, hist_done, hist_trig;
    logic [MW-1:0] m_eff;

    logic          bin_ok, load_warm, d_neg, gate_ok, out_free;
    logic [BW-1:0] bi;
    logic [23:0]   mag, mag_n;
    logic [3:0]    ld_cnt;
    logic [17:0]   thr3;
    logic [63:0]   vn_calc;

    bes_alu u_alu (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (alu_cmd),
        .opa    (alu_a),
        .opb    (alu_b),
        .done   (alu_done),
        .result (alu_res)
    );

    bes_hist #(
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_hist (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (hist_start),
        .spike  (sur_reg > thr_reg),
        .m_eff  (m_eff),
        .k_need (k_reg),
        .done   (hist_done),
        .trig   (hist_trig)
    );

    always_comb
    begin
        bin_ok    = (6'(bin_reg) < 6'(NUM_BINS));
        bi        = bin_reg[BW-1:0];
        ld_cnt    = vld_reg[bi] ? cnt_mem[bi] : 4'd0;
        load_warm = (5'(ld_cnt) < 5'(WARMUP_SAMPLES));
        d_neg     = (x_reg < mu_reg);
        mag       = absdiff24(x_reg, mu_reg);
        mag_n     = absdiff24(x_reg, nm_reg);
        thr3      = {1'b0, thr_reg, 1'b0} + {2'b00, thr_reg};
        // EWMA update only while 2 * surprise < 3 * threshold
        gate_ok   = ({1'b0, sur_reg, 1'b0} < thr3);
        out_free  = !m_tvalid_reg || m_tready;
        vn_calc   = {12'd0, v_reg} - p_reg + (alu_res >> 16);
        if (win_reg == 6'd0)
            m_eff = MW'(1);
        else if (7'(win_reg) > 7'(HISTORY_DEPTH))
            m_eff = MW'(HISTORY_DEPTH);
        else
            m_eff = MW'(win_reg);
    end

    // next state
    always_comb
    begin
        state_next    = state_reg;
        launched_next = launched_reg;
        case (state_reg)
            S_IDLE: if (s_tvalid) state_next = S_LOAD;
            S_LOAD:
            begin
                if (!bin_ok)
                    state_next = S_DONE;
                else if (load_warm)
                    state_next = S_W_DIV;
                else
                    state_next = S_V_DIV;
            end
            S_W_WB: state_next = S_DONE;
            S_GATE: state_next = gate_ok ? S_M1 : S_HIST;
            S_NM:   state_next = S_M3;
            S_WB:   state_next = S_HIST;
            S_DONE: if (out_free) state_next = S_IDLE;
            S_HIST:
            begin
                if (!launched_reg)
                    launched_next = 1'b1;
                else if (hist_done)
                begin
                    launched_next = 1'b0;
                    state_next    = S_DONE;
                end
            end
            default:
            begin
                // shared unit states
                if (!launched_reg)
                    launched_next = 1'b1;
                else if (alu_done)
                begin
                    launched_next = 1'b0;
                    case (state_reg)
                        S_W_DIV: state_next = S_W_MUL;
                        S_W_MUL: state_next = S_W_WB;
                        S_V_DIV: state_next = S_SQRT;
                        S_SQRT:  state_next = S_S_DIV;
                        S_S_DIV: state_next = S_GATE;
                        S_M1:    state_next = S_M2;
                        S_M2:    state_next = S_NM;
                        S_M3:    state_next = S_M4;
                        S_M4:    state_next = S_M5;
                        S_M5:    state_next = S_M6;
                        S_M6:    state_next = S_M7;
                        S_M7:    state_next = S_WB;
                        default: state_next = S_IDLE;
                    endcase
                end
            end
        endcase
    end

    // outputs and shared unit operands
    always_comb
    begin
        s_tready      = (state_reg == S_IDLE);
        hist_start    = (state_reg == S_HIST) && !launched_reg;
        alu_cmd.start = !launched_reg;
        alu_cmd.op    = ALU_MUL;
        alu_cmd.iters = IT_A;
        alu_a         = '0;
        alu_b         = '0;
        case (state_reg)
            S_W_DIV:
            begin
                alu_cmd.op = ALU_DIV; alu_cmd.iters = IT_WDIV;
                alu_a = 64'(mag); alu_b = 64'(cnt_reg);
            end
            S_W_MUL:
            begin
                alu_cmd.iters = IT_MAG;
                alu_a = 64'(mag); alu_b = 64'(mag_n);
            end
            S_V_DIV:
            begin
                alu_cmd.op = ALU_DIV; alu_cmd.iters = IT_VDIV;
                alu_a = 64'(vs_reg); alu_b = 64'(cnt_reg);
            end
            S_SQRT:
            begin
                alu_cmd.op = ALU_SQRT; alu_cmd.iters = IT_SQRT;
                alu_a = 64'(v_reg + EPS_Q24);
            end
            S_S_DIV:
            begin
                alu_cmd.op = ALU_DIV; alu_cmd.iters = IT_SDIV;
                alu_a = 64'({mag, 8'd0}); alu_b = 64'(s_reg);
            end
            S_M1:
            begin
                alu_cmd.iters = IT_A1;
                alu_a = 64'(mu_reg); alu_b = 64'(17'h10000 - 17'(alpha_reg));
            end
            S_M2:
            begin
                alu_a = 64'(x_reg); alu_b = 64'(alpha_reg);
            end
            S_M3:
            begin
                alu_cmd.iters = IT_MAG;
                alu_a = 64'(mag); alu_b = 64'(mag_n);
            end
            S_M4:
            begin
                alu_a = 64'(v_reg >> 16); alu_b = 64'(alpha_reg);
            end
            S_M5:
            begin
                alu_a = 64'(v_reg[15:0]); alu_b = 64'(alpha_reg);
            end
            S_M6:
            begin
                alu_a = 64'(inst_reg); alu_b = 64'(alpha_reg);
            end
            S_M7:
            begin
                alu_cmd.iters = IT_CNT;
                alu_a = vn_reg; alu_b = 64'(cnt_reg);
            end
            default:
            begin
                alu_cmd.start = 1'b0;
            end
        endcase
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {5'd0, o_trig_reg, o_sur_reg, o_warm_reg, o_acc_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            launched_reg <= 1'b0;
            alpha_reg    <= ALPHA_RST;
            thr_reg      <= THR_RST;
            k_reg        <= K_RST;
            win_reg      <= M_RST;
            vld_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            launched_reg <= launched_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_ALPHA: alpha_reg <= cfg_data;
                    REG_THR:   thr_reg   <= cfg_data;
                    REG_K:     k_reg     <= cfg_data[5:0];
                    REG_M:     win_reg   <= cfg_data[5:0];
                    default:   alpha_reg <= alpha_reg;
                endcase
            end
            if (state_reg == S_W_WB || state_reg == S_WB)
                vld_reg[bi] <= 1'b1;
            if (state_reg == S_DONE && out_free)
                m_tvalid_reg <= 1'b1;
            else if (m_tready)
                m_tvalid_reg <= 1'b0;
        end
    end

    // datapath and bin store
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                bin_reg <= s_tdata[4:0];
                x_reg   <= s_tdata[28:5];
            end
            S_LOAD:
            begin
                r_acc_reg  <= bin_ok;
                r_warm_reg <= bin_ok && load_warm;
                r_trig_reg <= 1'b0;
                sur_reg    <= '0;
                mu_reg     <= vld_reg[bi] ? mean_mem[bi] : 24'd0;
                vs_reg     <= vld_reg[bi] ? var_mem[bi] : 52'd0;
                cnt_reg    <= load_warm ? ld_cnt + 4'd1 : ld_cnt;
            end
            S_W_DIV:
            begin
                if (alu_done)
                    nm_reg <= d_neg ? mu_reg - alu_res[23:0] : mu_reg + alu_res[23:0];
            end
            S_W_MUL:
            begin
                if (alu_done)
                    vs_reg <= sat52(64'(vs_reg) + alu_res);
            end
            S_W_WB:
            begin
                mean_mem[bi] <= nm_reg;
                var_mem[bi]  <= vs_reg;
                cnt_mem[bi]  <= cnt_reg;
            end
            S_V_DIV:
            begin
                if (alu_done)
                    v_reg <= alu_res[51:0];
            end
            S_SQRT:
            begin
                if (alu_done)
                    s_reg <= alu_res[25:0];
            end
            S_S_DIV:
            begin
                if (alu_done)
                    sur_reg <= (alu_res > 64'hFFFF) ? 16'hFFFF : alu_res[15:0];
            end
            S_M1:
            begin
                if (alu_done)
                    p_reg <= alu_res;
            end
            S_M2:
            begin
                if (alu_done)
                    p_reg <= p_reg + alu_res;
            end
            S_NM:
            begin
                nm_reg <= 24'((p_reg + 64'd32768) >> 16);
            end
            S_M3:
            begin
                if (alu_done)
                    inst_reg <= alu_res[47:0];
            end
            S_M4:
            begin
                if (alu_done)
                    p_reg <= alu_res;
            end
            S_M5:
            begin
                if (alu_done)
                    p_reg <= p_reg + (alu_res >> 16);
            end
            S_M6:
            begin
                if (alu_done)
                    vn_reg <= vn_calc;
            end
            S_M7:
            begin
                if (alu_done)
                    vs_reg <= sat52(alu_res);
            end
            S_WB:
            begin
                mean_mem[bi] <= nm_reg;
                var_mem[bi]  <= vs_reg;
                cnt_mem[bi]  <= cnt_reg;
            end
            S_HIST:
            begin
                if (launched_reg && hist_done)
                    r_trig_reg <= hist_trig;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    o_acc_reg  <= r_acc_reg;
                    o_warm_reg <= r_warm_reg;
                    o_sur_reg  <= sur_reg;
                    o_trig_reg <= r_trig_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    // a warm-up result carries no score and no trigger
    a_warm_clean: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[1] |-> m_tdata[0] && m_tdata[17:2] == 16'd0 && !m_tdata[18])
        else $error("warm-up result with score or trigger");

    // a rejected item gives an all-zero result
    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[0] |-> m_tdata[18:1] == 18'd0)
        else $error("rejected item with nonzero fields");

    // no new item is taken while the shared unit still has a pending operation
    a_idle_launch: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> !launched_reg)
        else $error("ready while an operation is outstanding");

    // the history is only stepped from its own sequencer state
    a_hist_start: assert property (@(posedge clk) disable iff (!rst_n)
        hist_start |-> state_reg == S_HIST && r_acc_reg && !r_warm_reg)
        else $error("history started outside its state");

endmodule
`default_nettype wire

/* tb/binned_ewma_surprise_detector_unit_test.sv */
// Self-checking testbench for binned_ewma_surprise_detector_unit: directed and random items,
// register settings and handshake pressure, checked against an in-bench predictor.
// Depends on bes_pkg and the RTL of the block only.
`timescale 1ns / 100ps
`default_nettype none
module binned_ewma_surprise_detector_unit_test;
    import bes_pkg::*;

    localparam int N_BINS    = 24;
    localparam int HIST_LEN  = 32;
    localparam int WARM_CNT  = 10;
    localparam int STALL_MAX = 20000;

    typedef struct packed {
        bit        triggered;
        bit [15:0] surprise_score;
        bit        warming_up;
        bit        accepted;
    } det_result_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;

    binned_ewma_surprise_detector_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // predictor state
    bit [15:0] alpha_q16;
    bit [15:0] thr_q88;
    bit [5:0]  k_needed;
    bit [5:0]  m_window;
    bit [23:0] bin_mean_q[N_BINS];
    bit [51:0] bin_var_q[N_BINS];
    bit [3:0]  bin_cnt_q[N_BINS];
    bit        spike_ring[HIST_LEN];
    int        ring_ptr;

    det_result_t pending_results[$];
    bit [23:0]   bin_base[N_BINS];
    int          fail_count;
    int          send_idle_pct;
    int          recv_stall_pct;
    int          hold_off_req;
    int          quiet_cycles;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic bit [63:0] root_floor(bit [63:0] val);
        bit [63:0] res;
        bit [63:0] one;
        res = 0;
        one = 64'd1 << 62;
        while (one > val)
            one = one >> 2;
        while (one != 0)
        begin
            if (val >= res + one)
            begin
                val = val - (res + one);
                res = (res >> 1) + one;
            end
            else
                res = res >> 1;
            one = one >> 2;
        end
        return res;
    endfunction

    function automatic bit [51:0] clamp_var(bit [63:0] val);
        return (val > 64'h000F_FFFF_FFFF_FFFF) ? {52{1'b1}} : val[51:0];
    endfunction

    function automatic det_result_t predict_surprise(bit [4:0] b, bit [23:0] x);
        det_result_t r;
        longint      mu;
        longint      xs;
        longint      d;
        longint      dn;
        longint      mag;
        bit [63:0]   n;
        bit [63:0]   v;
        bit [63:0]   s;
        bit [63:0]   sur;
        bit [63:0]   a;
        bit [63:0]   nm;
        bit [63:0]   inst;
        bit [63:0]   vn;
        int          mm;
        int          act;
        r = '0;
        if (b >= N_BINS)
            return r;
        r.accepted = 1'b1;
        mu = longint'(bin_mean_q[b]);
        xs = longint'(x);
        n  = 64'(bin_cnt_q[b]);
        if (n < WARM_CNT)
        begin
            n = n + 1;
            bin_cnt_q[b] = n[3:0];
            d = xs - mu;
            mu = mu + d / longint'(n);
            bin_mean_q[b] = mu[23:0];
            bin_var_q[b] = clamp_var(64'(bin_var_q[b]) + 64'(d * (xs - mu)));
            r.warming_up = 1'b1;
            return r;
        end
        v = 64'(bin_var_q[b]) / n;
        s = root_floor(v + 64'd17);
        d = xs - mu;
        mag = (d < 0) ? -d : d;
        sur = (64'(mag) << 8) / s;
        if (sur > 64'hFFFF)
            sur = 64'hFFFF;
        r.surprise_score = sur[15:0];
        if (2 * sur < 3 * 64'(thr_q88))
        begin
            a = 64'(alpha_q16);
            nm = ((64'd65536 - a) * 64'(mu) + a * 64'(xs) + 64'd32768) >> 16;
            dn = xs - longint'(nm);
            inst = 64'(d * dn);
            bin_mean_q[b] = nm[23:0];
            vn = v - ((v >> 16) * a + (((v & 64'hFFFF) * a) >> 16)) + ((a * inst) >> 16);
            bin_var_q[b] = clamp_var(vn * n);
        end
        mm = int'(m_window);
        if (mm < 1)
            mm = 1;
        if (mm > HIST_LEN)
            mm = HIST_LEN;
        if (ring_ptr >= HIST_LEN)
            ring_ptr = 0;
        spike_ring[ring_ptr] = (sur > 64'(thr_q88));
        ring_ptr = (ring_ptr + 1) % mm;
        act = 0;
        for (int i = 0; i < mm; i++)
            act += spike_ring[i];
        r.triggered = (act >= int'(k_needed));
        return r;
    endfunction

    // called at a falling edge; returns at a falling edge
    task automatic send_item(bit [4:0] b, bit [23:0] x);
        s_tvalid = 1'b1;
        s_tdata  = {3'b000, x, b};
        forever
        begin
            @(posedge clk);
            if (s_tready)
                break;
        end
        pending_results.push_back(predict_surprise(b, x));
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid = 1'b0;
            @(negedge clk);
        end
    endtask

    task automatic wait_idle();
        s_tvalid = 1'b0;
        wait (pending_results.size() == 0);
        repeat (20) @(negedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, bit [15:0] val);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        @(negedge clk);
        cfg_we = 1'b0;
        case (idx)
            REG_ALPHA: alpha_q16 = val;
            REG_THR:   thr_q88   = val;
            REG_K:     k_needed  = val[5:0];
            default:   m_window  = val[5:0];
        endcase
    endtask

    task automatic set_regs(bit [15:0] a, bit [15:0] t, bit [15:0] k, bit [15:0] m);
        wait_idle();
        write_reg(REG_ALPHA, a);
        write_reg(REG_THR, t);
        write_reg(REG_K, k);
        write_reg(REG_M, m);
    endtask

    task automatic send_random_item();
        int        r;
        bit [4:0]  b;
        bit [23:0] x;
        int        noise;
        r = $urandom_range(99);
        b = 5'($urandom_range(N_BINS - 1));
        x = bin_base[b];
        noise = $urandom_range(int'(bin_base[b] >> 4));
        if (r < 8)
        begin
            b = 5'($urandom_range(31, N_BINS));
            x = 24'($urandom);
        end
        else if (r < 15)
            x = 24'($urandom);
        else if (r < 27)
            x = (bin_base[b] > 24'h55_0000) ? 24'hFF_FFFF : bin_base[b] * 3;
        else if (r < 30)
            x = 24'($urandom_range(int'(bin_base[b] >> 3)));
        else if ($urandom_range(1))
            x = bin_base[b] + 24'(noise);
        else
            x = bin_base[b] - 24'(noise);
        send_item(b, x);
    endtask

    task automatic test_directed();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        send_item(5'd24, 24'hFF_FFFF);
        send_item(5'd31, 24'h00_0000);
        send_item(5'd23, 24'hFF_FFFF);
        send_item(5'd23, 24'h00_0000);
        // constant warm-up on bin 0, then zero variance and a spike
        for (int i = 0; i < WARM_CNT; i++)
            send_item(5'd0, 24'h06_4000);
        send_item(5'd0, 24'h06_4000);
        send_item(5'd0, 24'hFF_FFFF);
        send_item(5'd0, 24'h00_0000);
        send_item(5'd0, 24'hFF_FFFF);
        send_item(5'd0, 24'h06_4000);
        send_item(5'd22, 24'hAA_AAAA);
        send_item(5'd22, 24'h55_5555);
        wait_idle();
    endtask

    task automatic test_random_phase(int n_items, int idle_pct, int stall_pct);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        for (int i = 0; i < n_items; i++)
            send_random_item();
        wait_idle();
    endtask

    task automatic test_backpressure();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        @(posedge clk);
        hold_off_req = 1500;
        @(negedge clk);
        for (int i = 0; i < 40; i++)
            send_random_item();
        wait_idle();
    endtask

    // receiver: random stalls, plus a counted hold-off when requested
    always @(negedge clk)
    begin
        if (hold_off_req > 0)
        begin
            m_tready = 1'b0;
            hold_off_req = hold_off_req - 1;
        end
        else
            m_tready = ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        det_result_t want;
        det_result_t got;
        if (m_tvalid && m_tready)
        begin
            got = det_result_t'(m_tdata[18:0]);
            if (pending_results.size() == 0)
            begin
                $error("result with no item pending: %h", m_tdata);
                fail_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (got.accepted != want.accepted)
                begin
                    $error("accepted: exp %0d got %0d", want.accepted, got.accepted);
                    fail_count++;
                end
                if (got.warming_up != want.warming_up)
                begin
                    $error("warming_up: exp %0d got %0d", want.warming_up, got.warming_up);
                    fail_count++;
                end
                if (got.surprise_score != want.surprise_score)
                begin
                    $error("surprise_score: exp %0d got %0d", want.surprise_score,
                           got.surprise_score);
                    fail_count++;
                end
                if (got.triggered != want.triggered)
                begin
                    $error("triggered: exp %0d got %0d", want.triggered, got.triggered);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
            quiet_cycles = 0;
        else
            quiet_cycles = quiet_cycles + 1;
        if (quiet_cycles >= STALL_MAX)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    initial
    begin
        clk       = 1'b0;
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        m_tready  = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = REG_ALPHA;
        cfg_data  = '0;
        fail_count     = 0;
        quiet_cycles   = 0;
        hold_off_req   = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        alpha_q16 = 16'd3277;
        thr_q88   = 16'd768;
        k_needed  = 6'd3;
        m_window  = 6'd5;
        ring_ptr  = 0;
        for (int i = 0; i < N_BINS; i++)
        begin
            bin_mean_q[i] = '0;
            bin_var_q[i]  = '0;
            bin_cnt_q[i]  = '0;
            bin_base[i]   = 24'($urandom_range(24'h40_0000, 24'h00_1000));
        end
        for (int i = 0; i < HIST_LEN; i++)
            spike_ring[i] = 1'b0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_directed();
        test_random_phase(300, 0, 0);
        set_regs(16'd65535, 16'd1, 16'd1, 16'd1);
        test_random_phase(250, 83, 0);
        set_regs(16'd0, 16'd65535, 16'd0, 16'd32);
        test_random_phase(250, 0, 83);
        set_regs(16'd1, 16'd256, 16'd32, 16'd32);
        test_random_phase(250, 17, 17);
        // lowering m leaves the pointer outside the window
        set_regs(16'($urandom_range(65535, 1)), 16'd512, 16'd2, 16'd0);
        test_random_phase(250, 0, 0);
        set_regs(16'd1000, 16'd1024, 16'd63, 16'd63);
        test_random_phase(200, 83, 0);
        test_backpressure();
        set_regs(16'd3277, 16'd384, 16'd3, 16'd7);
        test_random_phase(250, 17, 17);

        wait (pending_results.size() == 0);
        repeat (400) @(posedge clk);
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule
`default_nettype wire

/* files.f */
rtl/core/bes_pkg.sv
rtl/core/bes_alu.sv
rtl/core/bes_hist.sv
rtl/core/binned_ewma_surprise_detector_unit.sv
tb/binned_ewma_surprise_detector_unit_test.sv
